FILE: src/jfse_pkg.sv
// ----------------------------------------------------------------------------
// JPEG frame size extractor - shared package
// Widths, status codes, register indexes and the header byte pattern.
// ----------------------------------------------------------------------------
package jfse_pkg;

  localparam int unsigned DIM_W       = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_JFIF = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] DEFAULT_WIDTH_RST  = 16'd300;
  localparam logic [DIM_W-1:0] DEFAULT_HEIGHT_RST = 16'd376;

  typedef struct packed {
    logic                valid;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [STATUS_W-1:0] status;
  } result_t;

  // SOI + APP0 + "JFIF"; the two length bytes are not compared
  function automatic logic [BYTE_W-1:0] header_expect(input logic [3:0] idx);
    logic [BYTE_W-1:0] val;
    case (idx)
      4'd0:    val = 8'hFF;
      4'd1:    val = 8'hD8;
      4'd2:    val = 8'hFF;
      4'd3:    val = 8'hE0;
      4'd6:    val = 8'h4A;
      4'd7:    val = 8'h46;
      4'd8:    val = 8'h49;
      4'd9:    val = 8'h46;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic logic is_sof(input logic [BYTE_W-1:0] code);
    logic hit;
    case (code) inside
      [8'hC0:8'hC3], [8'hC9:8'hCB]: hit = 1'b1;
      default:                      hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

FILE: src/jfse_parser.sv
// ----------------------------------------------------------------------------
// JPEG frame size extractor - marker parser
// Per-byte state update: header check, segment skip, frame header capture.
// ----------------------------------------------------------------------------
module jfse_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [jfse_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          last_byte,
  input  logic [jfse_pkg::DIM_W-1:0]    default_width,
  input  logic [jfse_pkg::DIM_W-1:0]    default_height,
  output jfse_pkg::result_t             result
);

  localparam logic [3:0] PH_HEADER    = 4'd0;
  localparam logic [3:0] PH_MARK_FF   = 4'd1;
  localparam logic [3:0] PH_MARK_CODE = 4'd2;
  localparam logic [3:0] PH_LEN_HI    = 4'd3;
  localparam logic [3:0] PH_LEN_LO    = 4'd4;
  localparam logic [3:0] PH_SKIP      = 4'd5;
  localparam logic [3:0] PH_SOF       = 4'd6;
  localparam logic [3:0] PH_DONE      = 4'd7;

  logic [3:0]                      parse_phase, parse_phase_next;
  logic [3:0]                      byte_index, byte_index_next;
  logic [jfse_pkg::DIM_W-1:0]      skip_count, skip_count_next;
  logic [jfse_pkg::BYTE_W-1:0]     length_high, length_high_next;
  logic [jfse_pkg::DIM_W-1:0]      height_capture, height_capture_next;
  logic [jfse_pkg::DIM_W-1:0]      width_capture, width_capture_next;
  logic                            result_sent, result_sent_next;

  logic [3:0]                      hdr_idx;
  logic [jfse_pkg::DIM_W-1:0]      seg_len;
  logic [jfse_pkg::DIM_W-1:0]      skip_dec;

  assign hdr_idx  = (byte_index > 4'd9) ? 4'd9 : byte_index;
  assign seg_len  = {length_high, data_byte};
  assign skip_dec = (skip_count != '0) ? skip_count - 1'b1 : skip_count;

  always_comb begin
    parse_phase_next    = parse_phase;
    byte_index_next     = byte_index;
    skip_count_next     = skip_count;
    length_high_next    = length_high;
    height_capture_next = height_capture;
    width_capture_next  = width_capture;
    result_sent_next    = result_sent;
    result              = '0;

    case (parse_phase)
      PH_HEADER: begin
        if (hdr_idx != 4'd4 && hdr_idx != 4'd5 &&
            data_byte != jfse_pkg::header_expect(hdr_idx)) begin
          result = '{1'b1, default_width, default_height, jfse_pkg::ST_NOT_JFIF};
          result_sent_next = 1'b1;
          parse_phase_next = PH_DONE;
        end else begin
          if (hdr_idx == 4'd4) length_high_next = data_byte;
          if (hdr_idx == 4'd5) skip_count_next = seg_len;
          if (hdr_idx == 4'd9) begin
            skip_count_next  = (skip_count > 16'd6) ? skip_count - 16'd6 : '0;
            parse_phase_next = (skip_count > 16'd6) ? PH_SKIP : PH_MARK_FF;
            byte_index_next  = '0;
          end else begin
            byte_index_next = hdr_idx + 4'd1;
          end
        end
      end
      PH_MARK_FF: begin
        if (data_byte == 8'hFF) begin
          parse_phase_next = PH_MARK_CODE;
        end else begin
          result = '{1'b1, default_width, default_height, jfse_pkg::ST_NO_FRAME};
          result_sent_next = 1'b1;
          parse_phase_next = PH_DONE;
        end
      end
      PH_MARK_CODE: begin
        if (jfse_pkg::is_sof(data_byte)) begin
          parse_phase_next = PH_SOF;
          byte_index_next  = '0;
        end else begin
          parse_phase_next = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        length_high_next = data_byte;
        parse_phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_len > 16'd2) begin
          skip_count_next  = seg_len - 16'd2;
          parse_phase_next = PH_SKIP;
        end else begin
          skip_count_next  = '0;
          parse_phase_next = PH_MARK_FF;
        end
      end
      PH_SKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == '0) parse_phase_next = PH_MARK_FF;
      end
      PH_SOF: begin
        if (byte_index >= 4'd6) begin
          width_capture_next = width_capture | {8'h00, data_byte};
          result = '{1'b1, width_capture | {8'h00, data_byte}, height_capture,
                     jfse_pkg::ST_FOUND};
          result_sent_next = 1'b1;
          parse_phase_next = PH_DONE;
        end else begin
          if (byte_index == 4'd3) height_capture_next = {data_byte, 8'h00};
          if (byte_index == 4'd4) height_capture_next = height_capture | {8'h00, data_byte};
          if (byte_index == 4'd5) width_capture_next = {data_byte, 8'h00};
          byte_index_next = byte_index + 4'd1;
        end
      end
      default: begin
      end
    endcase

    if (last_byte) begin
      if (!result_sent_next) begin
        result = '{1'b1, default_width, default_height,
                   (parse_phase_next == PH_HEADER) ? jfse_pkg::ST_NOT_JFIF
                                                   : jfse_pkg::ST_NO_FRAME};
      end
      parse_phase_next    = PH_HEADER;
      byte_index_next     = '0;
      skip_count_next     = '0;
      length_high_next    = '0;
      height_capture_next = '0;
      width_capture_next  = '0;
      result_sent_next    = 1'b0;
    end

    if (!step) result = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_HEADER;
      byte_index     <= '0;
      skip_count     <= '0;
      length_high    <= '0;
      height_capture <= '0;
      width_capture  <= '0;
      result_sent    <= 1'b0;
    end else if (step) begin
      parse_phase    <= parse_phase_next;
      byte_index     <= byte_index_next;
      skip_count     <= skip_count_next;
      length_high    <= length_high_next;
      height_capture <= height_capture_next;
      width_capture  <= width_capture_next;
      result_sent    <= result_sent_next;
    end
  end

endmodule

FILE: src/jfse_out_reg.sv
// ----------------------------------------------------------------------------
// JPEG frame size extractor - result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module jfse_out_reg (
  input  logic                            clk,
  input  logic                            rst,
  input  jfse_pkg::result_t               result,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [jfse_pkg::DIM_W-1:0]      image_width,
  output logic [jfse_pkg::DIM_W-1:0]      image_height,
  output logic [jfse_pkg::STATUS_W-1:0]   parse_status
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      image_width  <= result.width;
      image_height <= result.height;
      parse_status <= result.status;
    end
  end

endmodule

FILE: src/jpeg_frame_size_extractor_top.sv
// ----------------------------------------------------------------------------
// JPEG frame size extractor - top level
// Parses a JPEG byte stream and reports the frame dimensions once per file.
// ----------------------------------------------------------------------------
// Input channel: one file byte per word (data_byte, last_byte), in_valid and
// in_ready. Output channel: one word per file (image_width, image_height,
// parse_status), out_valid and out_ready. Config channel: cfg_index selects
// default_width (0) or default_height (1), cfg_data is the value; always ready.
// An accepted input word sits in the input register; the byte FSM updates from
// it once the output slot is free, and any result is written to the output
// register at the end of that update cycle, which raises out_valid.
// Throughput is one byte per cycle while the output slot is free, set by the
// input register feeding the FSM update.
// While the output register holds an untaken result, the input register holds
// its byte and in_ready stays low until out_ready frees the output slot; every
// byte waits then, including bytes that give no result.
// Reset clears the parser, empties both registers and restores the defaults
// 300 x 376. After the byte flagged last_byte the parser restarts for the next
// file.
// ----------------------------------------------------------------------------
module jpeg_frame_size_extractor_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [jfse_pkg::BYTE_W-1:0]        data_byte,
  input  logic                               last_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [jfse_pkg::DIM_W-1:0]         image_width,
  output logic [jfse_pkg::DIM_W-1:0]         image_height,
  output logic [jfse_pkg::STATUS_W-1:0]      parse_status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [jfse_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [jfse_pkg::DIM_W-1:0]         cfg_data
);

  logic                            stage_valid;
  logic [jfse_pkg::BYTE_W-1:0]     stage_byte;
  logic                            stage_last;
  logic                            advance;
  logic [jfse_pkg::DIM_W-1:0]      default_width;
  logic [jfse_pkg::DIM_W-1:0]      default_height;
  jfse_pkg::result_t               result;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_width  <= jfse_pkg::DEFAULT_WIDTH_RST;
      default_height <= jfse_pkg::DEFAULT_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == jfse_pkg::REG_DEFAULT_WIDTH)  default_width  <= cfg_data;
      if (cfg_index == jfse_pkg::REG_DEFAULT_HEIGHT) default_height <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte <= data_byte;
      stage_last <= last_byte;
    end
  end

  jfse_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .data_byte      (stage_byte),
    .last_byte      (stage_last),
    .default_width  (default_width),
    .default_height (default_height),
    .result         (result)
  );

  jfse_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .result       (result),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .image_width  (image_width),
    .image_height (image_height),
    .parse_status (parse_status)
  );

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (parse_status == jfse_pkg::ST_FOUND ||
                   parse_status == jfse_pkg::ST_NOT_JFIF ||
                   parse_status == jfse_pkg::ST_NO_FRAME))
    else $error("invalid parse_status code");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_byte) && $stable(stage_last))
    else $error("stalled input word lost");

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken word");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !stage_valid)
    else $error("registers not empty after reset");

endmodule
